// ===== hw/rtl/sud_pkg.sv =====
// Shared types and constants for the 64-bit signed/unsigned divider.
`default_nettype none

package sud_pkg;

    localparam int DATA_WIDTH = 64;

    localparam logic [1:0] FUNC_UQUO = 2'd0;
    localparam logic [1:0] FUNC_UREM = 2'd1;
    localparam logic [1:0] FUNC_SQUO = 2'd2;
    localparam logic [1:0] FUNC_SREM = 2'd3;

    typedef struct packed {
        logic [1:0]            func;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } in_word_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result;
        logic                  divide_by_zero;
    } out_word_t;

    typedef struct packed {
        logic                  valid;
        logic                  rem_sel;
        logic                  neg;
        logic                  dz;
        logic [DATA_WIDTH-1:0] den;
        logic [DATA_WIDTH-1:0] numq;
        logic [DATA_WIDTH-1:0] rem;
    } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sud_prep.sv =====
// Operand stage: magnitudes, sign flags and zero-divisor detect.
`default_nettype none

module sud_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  sud_pkg::in_word_t word,
    output sud_pkg::stage_t  stage
);
    import sud_pkg::*;

    logic                  sgn;
    logic                  nneg;
    logic                  dneg;
    logic [DATA_WIDTH-1:0] nmag;
    logic [DATA_WIDTH-1:0] dmag;
    logic                  valid_reg;
    stage_t                data_reg;
    stage_t                data_next;

    always_comb
    begin
        sgn  = (word.func inside {FUNC_SQUO, FUNC_SREM});
        nneg = sgn && word.dividend[DATA_WIDTH-1];
        dneg = sgn && word.divisor[DATA_WIDTH-1];
        nmag = nneg ? (~word.dividend + 1'b1) : word.dividend;
        dmag = dneg ? (~word.divisor + 1'b1) : word.divisor;
        data_next.valid   = valid;
        data_next.rem_sel = (word.func inside {FUNC_UREM, FUNC_SREM});
        data_next.neg     = data_next.rem_sel ? nneg : (nneg ^ dneg);
        data_next.dz      = (word.divisor == '0);
        data_next.den     = dmag;
        data_next.numq    = nmag;
        data_next.rem     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sud_cell.sv =====
// One restoring shift-subtract step: one quotient bit per cell.
`default_nettype none

module sud_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  sud_pkg::stage_t prev,
    output sud_pkg::stage_t stage
);
    import sud_pkg::*;

    logic                  carry;
    logic [DATA_WIDTH-1:0] sh;
    logic [DATA_WIDTH:0]   diff;
    logic                  take;
    logic                  valid_reg;
    stage_t                data_reg;
    stage_t                data_next;

    always_comb
    begin
        carry = prev.rem[DATA_WIDTH-1];
        sh    = {prev.rem[DATA_WIDTH-2:0], prev.numq[DATA_WIDTH-1]};
        diff  = {carry, sh} - {1'b0, prev.den};
        take  = !diff[DATA_WIDTH];
        data_next      = prev;
        data_next.rem  = take ? diff[DATA_WIDTH-1:0] : sh;
        data_next.numq = {prev.numq[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= prev.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sud_fix.sv =====
// Result stage: select quotient or remainder, apply sign, force zero.
`default_nettype none

module sud_fix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  sud_pkg::stage_t    prev,
    output logic               valid,
    output sud_pkg::out_word_t word
);
    import sud_pkg::*;

    logic [DATA_WIDTH-1:0] val;
    logic                  valid_reg;
    out_word_t             word_reg;
    out_word_t             word_next;

    always_comb
    begin
        val = prev.rem_sel ? prev.rem : prev.numq;
        if (prev.dz)
            word_next.result = '0;
        else if (prev.neg)
            word_next.result = ~val + 1'b1;
        else
            word_next.result = val;
        word_next.divide_by_zero = prev.dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= prev.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_unsigned_divider_64.sv =====
// Top level of the pipelined 64-bit signed/unsigned divider.
//
// Accepts one word per cycle while req_stall is low and returns one result word per input,
// in order, once it has passed through one operand stage (magnitudes and
// zero-divisor detect), a chain of 64 divide cells that each resolve one quotient bit,
// and one result stage (select, sign and zero forcing). The whole chain advances together;
// req_stall is high exactly while a result word waits on rsp_stall.
`default_nettype none

module signed_unsigned_divider_64 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sud_pkg::in_word_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sud_pkg::out_word_t rsp_word
);
    import sud_pkg::*;

    logic   adv;
    stage_t chain [0:DATA_WIDTH];

    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    sud_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .valid (req_valid),
        .word  (req_word),
        .stage (chain[0])
    );

    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_cell
        sud_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .prev  (chain[k]),
            .stage (chain[k+1])
        );
    end

    sud_fix u_fix (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .prev  (chain[DATA_WIDTH]),
        .valid (rsp_valid),
        .word  (rsp_word)
    );

`ifndef SYNTH
    a_zero_result : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.divide_by_zero) |-> (rsp_word.result == '0))
        else $error("divide by zero with nonzero result");

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> chain[0].valid)
        else $error("accepted word missing from operand stage");

    a_last_to_out : assert property (@(posedge clk) disable iff (!rst_n)
        (chain[DATA_WIDTH].valid && adv) |=> rsp_valid)
        else $error("last cell word lost before output");

    a_hold_chain : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain[0].valid) && $stable(chain[DATA_WIDTH].valid))
        else $error("chain moved while stalled");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the pipelined 64-bit signed/unsigned divider: directed and random words.
`default_nettype none

module testbench;

    import sud_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] ALL_ONES = '1;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = ~MOST_NEG;

    typedef struct {
        in_word_t  stim;
        out_word_t want;
    } division_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_word_t  req_word = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_word_t rsp_word;

    division_t   pending_divisions[$];
    int unsigned fault_count = 0;
    bit          steady = 1'b0;

    signed_unsigned_divider_64 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [W-1:0] magnitude_of(logic [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    function automatic out_word_t divide_word(in_word_t w);
        out_word_t    o;
        logic [W-1:0] num;
        logic [W-1:0] den;
        logic [W-1:0] quo;
        logic [W-1:0] rem;
        logic         carry;
        logic         is_signed;
        o.result = '0;
        o.divide_by_zero = (w.divisor == '0);
        if (o.divide_by_zero)
            return o;
        is_signed = (w.func == FUNC_SQUO) || (w.func == FUNC_SREM);
        num = is_signed ? magnitude_of(w.dividend) : w.dividend;
        den = is_signed ? magnitude_of(w.divisor) : w.divisor;
        quo = '0;
        rem = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            carry = rem[W-1];
            rem = {rem[W-2:0], num[i]};
            if (carry || rem >= den)
            begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        case (w.func)
            FUNC_UQUO: o.result = quo;
            FUNC_UREM: o.result = rem;
            FUNC_SQUO: o.result = (w.dividend[W-1] ^ w.divisor[W-1]) ? -quo : quo;
            FUNC_SREM: o.result = w.dividend[W-1] ? -rem : rem;
            default:   o.result = '0;
        endcase
        return o;
    endfunction

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%t mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin : result_check
        division_t head;
        if (rst_n && req_valid && !req_stall)
            pending_divisions.push_back('{stim: req_word, want: divide_word(req_word)});
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_divisions.size() == 0)
            begin
                report_fault($sformatf("unexpected word result %h dz %b",
                                       rsp_word.result, rsp_word.divide_by_zero));
            end
            else
            begin
                head = pending_divisions.pop_front();
                if (rsp_word.result !== head.want.result)
                    report_fault($sformatf("func %0d %h / %h: result expected %h got %h",
                                           head.stim.func, head.stim.dividend,
                                           head.stim.divisor, head.want.result,
                                           rsp_word.result));
                if (rsp_word.divide_by_zero !== head.want.divide_by_zero)
                    report_fault($sformatf("func %0d %h / %h: dz expected %b got %b",
                                           head.stim.func, head.stim.dividend,
                                           head.stim.divisor, head.want.divide_by_zero,
                                           rsp_word.divide_by_zero));
            end
        end
    end

    initial
    begin : result_sink
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 11);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
        end
    end

    task automatic issue_division(input logic [1:0] func, input logic [W-1:0] dividend,
                                  input logic [W-1:0] divisor);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= '{func: func, dividend: dividend, divisor: divisor};
        do @(posedge clk); while (req_stall);
    endtask

    function automatic logic [W-1:0] pick_operand();
        logic [W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return v;
            1: return v >> $urandom_range(0, W - 1);
            2: return -(v >> $urandom_range(0, W - 1));
            3: return W'($urandom_range(0, 15));
            4:
            begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return W'(1);
                    2: return ALL_ONES;
                    3: return MOST_NEG;
                    default: return MOST_POS;
                endcase
            end
            default: return W'(1) << $urandom_range(0, W - 1);
        endcase
    endfunction

    task automatic issue_random();
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        dividend = pick_operand();
        divisor = ($urandom_range(0, 31) == 0) ? '0 : pick_operand();
        issue_division(2'($urandom_range(0, 3)), dividend, divisor);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_divisions.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        issue_division(FUNC_UQUO, '0, '0);
        issue_division(FUNC_UREM, ALL_ONES, '0);
        issue_division(FUNC_SQUO, MOST_NEG, '0);
        issue_division(FUNC_SREM, W'(1), '0);
        issue_division(FUNC_UQUO, ALL_ONES, W'(1));
        issue_division(FUNC_UQUO, ALL_ONES, MOST_NEG);
        issue_division(FUNC_UREM, ALL_ONES, MOST_NEG);
        issue_division(FUNC_UQUO, '0, ALL_ONES);
        issue_division(FUNC_UREM, MOST_POS, ALL_ONES);
        issue_division(FUNC_UQUO, ALL_ONES, ALL_ONES);
        issue_division(FUNC_SQUO, MOST_NEG, ALL_ONES);
        issue_division(FUNC_SREM, MOST_NEG, ALL_ONES);
        issue_division(FUNC_SQUO, MOST_NEG, W'(1));
        issue_division(FUNC_SREM, MOST_NEG, MOST_NEG);
        issue_division(FUNC_SQUO, MOST_POS, MOST_NEG);
        issue_division(FUNC_SQUO, W'(-7), W'(2));
        issue_division(FUNC_SREM, W'(-7), W'(2));
        issue_division(FUNC_SQUO, W'(7), W'(-2));
        issue_division(FUNC_SREM, W'(7), W'(-2));
        issue_division(FUNC_SQUO, W'(-7), W'(-2));
        issue_division(FUNC_SREM, W'(-7), W'(-2));
    endtask

    task automatic test_random(input int unsigned count);
        repeat (count) issue_random();
    endtask

    task automatic test_back_to_back(input int unsigned count);
        steady = 1'b1;
        repeat (count) issue_random();
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_drained_pause();
        repeat (30) issue_random();
        wait_drained();
        repeat (30) issue_random();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1000);
        test_back_to_back(200);
        test_drained_pause();
        test_random(100);
        wait_drained();
        repeat (80) @(posedge clk);
        if (fault_count == 0 && pending_divisions.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
